// ===== sv/tqh_pkg.sv =====
package tqh_pkg;

  localparam int unsigned DL_W = 32;
  localparam int unsigned TAG_W = 32;
  localparam int unsigned OH_W = 8;
  localparam int unsigned FN_W = 2;
  localparam int unsigned STS_W = 2;

  localparam logic [FN_W-1:0] FN_SCHED  = 2'd0;
  localparam logic [FN_W-1:0] FN_CANCEL = 2'd1;
  localparam logic [FN_W-1:0] FN_FIRE   = 2'd2;

  localparam logic [STS_W-1:0] STS_OK    = 2'd0;
  localparam logic [STS_W-1:0] STS_EMPTY = 2'd1;
  localparam logic [STS_W-1:0] STS_FULL  = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ALLOC,
    ST_UP_RD,
    ST_UP_CMP,
    ST_F_TOP,
    ST_F_CHK,
    ST_P_LAST,
    ST_D_L,
    ST_D_LW,
    ST_D_RW,
    ST_D_CMP,
    ST_DONE
  } st_e;

endpackage

// ===== sv/tqh_ram.sv =====
module tqh_ram #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/timer_heap_with_handle_free_list.sv =====
// Timer queue with a binary min-heap of (deadline, handle) and a handle free
// list. One request at a time: func 0 schedules (returns the new handle, or
// status 2 when all CAPACITY handles are taken), func 1 cancels a handle
// (lazy: its heap entry stays until it reaches the top), func 2 fires the
// earliest live timer (status 1 when none is left). The heap sits in a
// RAM with one write and one read port and registered reads, and one
// deadline comparator is shared by every heap step, so the work per
// request grows with the heap depth log2(CAPACITY). Cancel, the undefined
// code and a schedule with no free handle go straight to the response;
// schedule allocates a handle and sifts the new entry up a level at a
// time; fire reads the top entry, frees its handle (firing it when live,
// else discarding it), moves the last entry to the root and sifts it
// down, repeating until a live timer fires or the heap is empty.
// in_ready_o is high only while the sequencer is idle; a finished response
// waits in an output register, so the next request is taken even while the
// previous response is still unclaimed.
module timer_heap_with_handle_free_list #(
  parameter int unsigned CAPACITY = 256
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [tqh_pkg::FN_W-1:0]    func_i,
  input  logic [tqh_pkg::DL_W-1:0]    deadline_i,
  input  logic [tqh_pkg::TAG_W-1:0]   user_tag_i,
  input  logic [tqh_pkg::OH_W-1:0]    handle_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [tqh_pkg::STS_W-1:0]   status_o,
  output logic [tqh_pkg::OH_W-1:0]    out_handle_o,
  output logic [tqh_pkg::TAG_W-1:0]   fired_tag_o,
  output logic [tqh_pkg::DL_W-1:0]    fired_deadline_o
);
  import tqh_pkg::*;

  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned EW = DL_W + IW;
  localparam logic [CW-1:0] CAPC = CW'(CAPACITY);

  // sequencer and control state
  st_e st_q, st_d;
  logic fired_q, fired_d;
  logic from_list_q, from_list_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] free_head_q, free_head_d;
  logic [CW-1:0] alloc_q, alloc_d;
  logic [CAPACITY-1:0] live_q, live_d;
  logic out_valid_q, out_valid_d;

  // payload registers
  logic [DL_W-1:0] x_dl_q, x_dl_d;
  logic [IW-1:0] x_h_q, x_h_d;
  logic [TAG_W-1:0] tag_q, tag_d;
  logic [CW-1:0] i_q, i_d;
  logic [DL_W-1:0] c_dl_q, c_dl_d;
  logic [IW-1:0] c_h_q, c_h_d;
  logic [CW-1:0] c_idx_q, c_idx_d;
  logic [STS_W-1:0] res_sts_q, res_sts_d;
  logic [OH_W-1:0] res_h_q, res_h_d;
  logic [TAG_W-1:0] res_tag_q, res_tag_d;
  logic [DL_W-1:0] res_dl_q, res_dl_d;
  logic [STS_W-1:0] o_sts_q, o_sts_d;
  logic [OH_W-1:0] o_h_q, o_h_d;
  logic [TAG_W-1:0] o_tag_q, o_tag_d;
  logic [DL_W-1:0] o_dl_q, o_dl_d;

  // RAM ports
  logic heap_we, heap_re, tag_we, tag_re, nxt_we, nxt_re;
  logic [IW-1:0] heap_waddr, heap_raddr, tag_waddr, tag_raddr, nxt_waddr, nxt_raddr;
  logic [EW-1:0] heap_wdata, heap_rdata;
  logic [TAG_W-1:0] tag_rdata;
  logic [CW-1:0] nxt_wdata, nxt_rdata;

  logic [DL_W-1:0] rd_dl;
  logic [IW-1:0] rd_h;
  assign rd_dl = heap_rdata[EW-1:IW];
  assign rd_h  = heap_rdata[IW-1:0];

  // shared deadline comparator
  logic [DL_W-1:0] cmp_a, cmp_b;
  logic cmp_lt;
  always_comb begin
    case (st_q)
      ST_UP_CMP: begin
        cmp_a = x_dl_q;
        cmp_b = rd_dl;
      end
      ST_D_RW: begin
        cmp_a = rd_dl;
        cmp_b = c_dl_q;
      end
      default: begin
        cmp_a = c_dl_q;
        cmp_b = x_dl_q;
      end
    endcase
  end
  assign cmp_lt = cmp_a < cmp_b;

  logic in_acc;
  logic sched_list, sched_fresh;
  logic [CW:0] left_idx, right_idx;
  logic [CW-1:0] parent_idx;
  logic top_live;

  assign in_ready_o = (st_q == ST_IDLE);
  assign in_acc = in_valid_i && in_ready_o;
  assign sched_list = (free_head_q != alloc_q) && (free_head_q < CAPC);
  assign sched_fresh = alloc_q < CAPC;
  assign left_idx = ({1'b0, i_q} << 1) | (CW+1)'(1);
  assign right_idx = left_idx + (CW+1)'(1);
  assign parent_idx = (i_q - CW'(1)) >> 1;
  assign top_live = live_q[rd_h];

  // next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (func_i)
            FN_SCHED:  st_d = (sched_list || sched_fresh) ? ST_ALLOC : ST_DONE;
            FN_FIRE:   st_d = ST_F_TOP;
            default:   st_d = ST_DONE;
          endcase
        end
      end
      ST_ALLOC:  st_d = (count_q < CAPC) ? ST_UP_RD : ST_DONE;
      ST_UP_RD:  st_d = (i_q == '0) ? ST_DONE : ST_UP_CMP;
      ST_UP_CMP: st_d = cmp_lt ? ST_UP_RD : ST_DONE;
      ST_F_TOP:  st_d = (count_q == '0) ? ST_DONE : ST_F_CHK;
      ST_F_CHK:  st_d = ST_P_LAST;
      ST_P_LAST: begin
        if (count_q != '0) begin
          st_d = ST_D_L;
        end else begin
          st_d = fired_q ? ST_DONE : ST_F_TOP;
        end
      end
      ST_D_L: begin
        if (left_idx >= {1'b0, count_q}) begin
          st_d = fired_q ? ST_DONE : ST_F_TOP;
        end else begin
          st_d = ST_D_LW;
        end
      end
      ST_D_LW:  st_d = (right_idx < {1'b0, count_q}) ? ST_D_RW : ST_D_CMP;
      ST_D_RW:  st_d = ST_D_CMP;
      ST_D_CMP: begin
        if (cmp_lt) begin
          st_d = ST_D_L;
        end else begin
          st_d = fired_q ? ST_DONE : ST_F_TOP;
        end
      end
      ST_DONE:  st_d = (!out_valid_q || out_ready_i) ? ST_IDLE : ST_DONE;
      default:  st_d = ST_IDLE;
    endcase
  end

  // datapath and RAM control
  always_comb begin
    fired_d = fired_q;
    from_list_d = from_list_q;
    count_d = count_q;
    free_head_d = free_head_q;
    alloc_d = alloc_q;
    live_d = live_q;
    out_valid_d = out_valid_q;
    x_dl_d = x_dl_q;
    x_h_d = x_h_q;
    tag_d = tag_q;
    i_d = i_q;
    c_dl_d = c_dl_q;
    c_h_d = c_h_q;
    c_idx_d = c_idx_q;
    res_sts_d = res_sts_q;
    res_h_d = res_h_q;
    res_tag_d = res_tag_q;
    res_dl_d = res_dl_q;
    o_sts_d = o_sts_q;
    o_h_d = o_h_q;
    o_tag_d = o_tag_q;
    o_dl_d = o_dl_q;
    heap_we = 1'b0;
    heap_waddr = IW'(i_q);
    heap_wdata = {x_dl_q, x_h_q};
    heap_re = 1'b0;
    heap_raddr = '0;
    tag_we = 1'b0;
    tag_waddr = x_h_q;
    tag_re = 1'b0;
    tag_raddr = rd_h;
    nxt_we = 1'b0;
    nxt_waddr = rd_h;
    nxt_wdata = free_head_q;
    nxt_re = 1'b0;
    nxt_raddr = free_head_q[IW-1:0];

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (st_q)
      ST_IDLE: begin
        if (in_acc) begin
          res_sts_d = STS_OK;
          res_h_d = '0;
          res_tag_d = '0;
          res_dl_d = '0;
          fired_d = 1'b0;
          x_dl_d = deadline_i;
          tag_d = user_tag_i;
          case (func_i)
            FN_SCHED: begin
              if (sched_list) begin
                nxt_re = 1'b1;
                x_h_d = free_head_q[IW-1:0];
                from_list_d = 1'b1;
              end else if (sched_fresh) begin
                x_h_d = alloc_q[IW-1:0];
                alloc_d = alloc_q + CW'(1);
                free_head_d = alloc_q + CW'(1);
                from_list_d = 1'b0;
              end else begin
                res_sts_d = STS_FULL;
              end
            end
            FN_CANCEL: begin
              if (32'(handle_i) < 32'(CAPACITY)) begin
                live_d[IW'(handle_i)] = 1'b0;
              end
            end
            default: ;
          endcase
        end
      end
      ST_ALLOC: begin
        if (from_list_q) begin
          free_head_d = nxt_rdata;
        end
        tag_we = 1'b1;
        live_d[x_h_q] = 1'b1;
        res_h_d = OH_W'(x_h_q);
        if (count_q < CAPC) begin
          i_d = count_q;
          count_d = count_q + CW'(1);
        end
      end
      ST_UP_RD: begin
        if (i_q == '0) begin
          heap_we = 1'b1;
        end else begin
          heap_re = 1'b1;
          heap_raddr = IW'(parent_idx);
        end
      end
      ST_UP_CMP: begin
        heap_we = 1'b1;
        if (cmp_lt) begin
          heap_wdata = heap_rdata;
          i_d = parent_idx;
        end
      end
      ST_F_TOP: begin
        if (count_q == '0) begin
          res_sts_d = STS_EMPTY;
        end else begin
          heap_re = 1'b1;
          heap_raddr = '0;
        end
      end
      ST_F_CHK: begin
        // free the top handle, fired or discarded
        nxt_we = 1'b1;
        free_head_d = CW'(rd_h);
        if (top_live) begin
          fired_d = 1'b1;
          live_d[rd_h] = 1'b0;
          res_h_d = OH_W'(rd_h);
          res_dl_d = rd_dl;
          tag_re = 1'b1;
        end
        count_d = count_q - CW'(1);
        heap_re = 1'b1;
        heap_raddr = IW'(count_q - CW'(1));
      end
      ST_P_LAST: begin
        if (fired_q) begin
          res_tag_d = tag_rdata;
        end
        x_dl_d = rd_dl;
        x_h_d = rd_h;
        i_d = '0;
      end
      ST_D_L: begin
        if (left_idx >= {1'b0, count_q}) begin
          heap_we = 1'b1;
        end else begin
          heap_re = 1'b1;
          heap_raddr = IW'(left_idx);
        end
      end
      ST_D_LW: begin
        c_dl_d = rd_dl;
        c_h_d = rd_h;
        c_idx_d = CW'(left_idx);
        if (right_idx < {1'b0, count_q}) begin
          heap_re = 1'b1;
          heap_raddr = IW'(right_idx);
        end
      end
      ST_D_RW: begin
        // right child wins only when strictly earlier
        if (cmp_lt) begin
          c_dl_d = rd_dl;
          c_h_d = rd_h;
          c_idx_d = c_idx_q + CW'(1);
        end
      end
      ST_D_CMP: begin
        heap_we = 1'b1;
        if (cmp_lt) begin
          heap_wdata = {c_dl_q, c_h_q};
          i_d = c_idx_q;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          o_sts_d = res_sts_q;
          o_h_d = res_h_q;
          o_tag_d = res_tag_q;
          o_dl_d = res_dl_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
      fired_q <= 1'b0;
      from_list_q <= 1'b0;
      count_q <= '0;
      free_head_q <= '0;
      alloc_q <= '0;
      live_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      fired_q <= fired_d;
      from_list_q <= from_list_d;
      count_q <= count_d;
      free_head_q <= free_head_d;
      alloc_q <= alloc_d;
      live_q <= live_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_dl_q <= x_dl_d;
    x_h_q <= x_h_d;
    tag_q <= tag_d;
    i_q <= i_d;
    c_dl_q <= c_dl_d;
    c_h_q <= c_h_d;
    c_idx_q <= c_idx_d;
    res_sts_q <= res_sts_d;
    res_h_q <= res_h_d;
    res_tag_q <= res_tag_d;
    res_dl_q <= res_dl_d;
    o_sts_q <= o_sts_d;
    o_h_q <= o_h_d;
    o_tag_q <= o_tag_d;
    o_dl_q <= o_dl_d;
  end

  // heap slots: {deadline, handle}
  tqh_ram #(.DEPTH(CAPACITY), .WIDTH(EW)) u_heap (
    .clk_i   (clk_i),
    .we_i    (heap_we),
    .waddr_i (heap_waddr),
    .wdata_i (heap_wdata),
    .re_i    (heap_re),
    .raddr_i (heap_raddr),
    .rdata_o (heap_rdata)
  );

  // user tag per handle
  tqh_ram #(.DEPTH(CAPACITY), .WIDTH(TAG_W)) u_tag (
    .clk_i   (clk_i),
    .we_i    (tag_we),
    .waddr_i (tag_waddr),
    .wdata_i (tag_q),
    .re_i    (tag_re),
    .raddr_i (tag_raddr),
    .rdata_o (tag_rdata)
  );

  // free-list links
  tqh_ram #(.DEPTH(CAPACITY), .WIDTH(CW)) u_next (
    .clk_i   (clk_i),
    .we_i    (nxt_we),
    .waddr_i (nxt_waddr),
    .wdata_i (nxt_wdata),
    .re_i    (nxt_re),
    .raddr_i (nxt_raddr),
    .rdata_o (nxt_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign status_o = o_sts_q;
  assign out_handle_o = o_h_q;
  assign fired_tag_o = o_tag_q;
  assign fired_deadline_o = o_dl_q;

endmodule

// ===== sv/tqh_check.sv =====
module tqh_check (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [tqh_pkg::STS_W-1:0]   status_o,
  input logic [tqh_pkg::OH_W-1:0]    out_handle_o,
  input logic [tqh_pkg::TAG_W-1:0]   fired_tag_o,
  input logic [tqh_pkg::DL_W-1:0]    fired_deadline_o
);
  import tqh_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o))
    else $error("response dropped while stalled");

  a_sts_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o == STS_OK || status_o == STS_EMPTY || status_o == STS_FULL)
    else $error("undefined status code");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != STS_OK |->
      out_handle_o == '0 && fired_tag_o == '0 && fired_deadline_o == '0)
    else $error("failed request carries data");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while busy");

endmodule

bind timer_heap_with_handle_free_list tqh_check u_tqh_check (.*);

// ===== bench/tqh_checker.sv =====
`timescale 1ns / 1ps

module tqh_checker #(
  parameter int unsigned CAPACITY = 256
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      in_ready_i,
  input  logic [tqh_pkg::FN_W-1:0]  func_i,
  input  logic [tqh_pkg::DL_W-1:0]  deadline_i,
  input  logic [tqh_pkg::TAG_W-1:0] user_tag_i,
  input  logic [tqh_pkg::OH_W-1:0]  handle_i,
  input  logic                      out_valid_i,
  input  logic                      out_ready_i,
  input  logic [tqh_pkg::STS_W-1:0] status_i,
  input  logic [tqh_pkg::OH_W-1:0]  out_handle_i,
  input  logic [tqh_pkg::TAG_W-1:0] fired_tag_i,
  input  logic [tqh_pkg::DL_W-1:0]  fired_deadline_i,
  output int                        pending_o,
  output int                        fail_count_o
);
  import tqh_pkg::*;

  typedef struct packed {
    logic [STS_W-1:0] status;
    logic [OH_W-1:0]  handle;
    logic [TAG_W-1:0] tag;
    logic [DL_W-1:0]  deadline;
  } timer_resp_t;

  timer_resp_t resp_q[$];

  // shadow timer queue
  logic [DL_W-1:0]  slot_dl[CAPACITY];
  int unsigned      slot_hd[CAPACITY];
  int unsigned      slot_cnt;
  logic [TAG_W-1:0] tag_of[CAPACITY];
  bit               live[CAPACITY];
  int unsigned      link[CAPACITY];
  int unsigned      free_top;
  int unsigned      fresh_cnt;

  function automatic void swap_slots(int unsigned a, int unsigned b);
    logic [DL_W-1:0] d;
    int unsigned h;
    d = slot_dl[a]; h = slot_hd[a];
    slot_dl[a] = slot_dl[b]; slot_hd[a] = slot_hd[b];
    slot_dl[b] = d; slot_hd[b] = h;
  endfunction

  function automatic void release_handle(int unsigned h);
    link[h] = free_top;
    free_top = h;
  endfunction

  function automatic void heap_insert(logic [DL_W-1:0] d, int unsigned h);
    int unsigned i;
    int unsigned p;
    i = slot_cnt;
    slot_cnt++;
    slot_dl[i] = d;
    slot_hd[i] = h;
    while (i > 0) begin
      p = (i - 1) / 2;
      if (slot_dl[i] < slot_dl[p]) begin
        swap_slots(i, p);
        i = p;
      end else begin
        break;
      end
    end
  endfunction

  function automatic void heap_remove_top();
    int unsigned i, l, c;
    i = 0;
    slot_cnt--;
    slot_dl[0] = slot_dl[slot_cnt];
    slot_hd[0] = slot_hd[slot_cnt];
    forever begin
      l = 2 * i + 1;
      if (l >= slot_cnt) break;
      c = l;
      // tie goes to the left child
      if (l + 1 < slot_cnt && slot_dl[l + 1] < slot_dl[l]) c = l + 1;
      if (slot_dl[c] < slot_dl[i]) begin
        swap_slots(i, c);
        i = c;
      end else begin
        break;
      end
    end
  endfunction

  function automatic timer_resp_t timer_queue_step(logic [FN_W-1:0] fn, logic [DL_W-1:0] d,
                                                   logic [TAG_W-1:0] t, logic [OH_W-1:0] hin);
    timer_resp_t r;
    int unsigned h;
    r = '0;
    if (fn == FN_SCHED) begin
      if (free_top != fresh_cnt && free_top < CAPACITY) begin
        h = free_top;
        free_top = link[h];
      end else if (fresh_cnt < CAPACITY) begin
        h = fresh_cnt;
        fresh_cnt++;
        free_top = fresh_cnt;
      end else begin
        r.status = STS_FULL;
        return r;
      end
      tag_of[h] = t;
      live[h] = 1'b1;
      heap_insert(d, h);
      r.handle = h[OH_W-1:0];
    end else if (fn == FN_CANCEL) begin
      if (hin < CAPACITY) live[hin] = 1'b0;
    end else if (fn == FN_FIRE) begin
      // drop cancelled entries sitting at the top
      while (slot_cnt > 0 && !live[slot_hd[0]]) begin
        release_handle(slot_hd[0]);
        heap_remove_top();
      end
      if (slot_cnt == 0) begin
        r.status = STS_EMPTY;
        return r;
      end
      h = slot_hd[0];
      r.handle = h[OH_W-1:0];
      r.tag = tag_of[h];
      r.deadline = slot_dl[0];
      live[h] = 1'b0;
      release_handle(h);
      heap_remove_top();
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    timer_resp_t exp_r;
    if (!rst_ni) begin
      resp_q.delete();
      slot_cnt = 0;
      free_top = 0;
      fresh_cnt = 0;
      for (int i = 0; i < CAPACITY; i++) live[i] = 1'b0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (resp_q.size() == 0) begin
          $error("response with no request outstanding");
          fail_count_o++;
        end else begin
          exp_r = resp_q.pop_front();
          if (status_i !== exp_r.status) begin
            $error("status: expected %0d, got %0d", exp_r.status, status_i);
            fail_count_o++;
          end
          if (out_handle_i !== exp_r.handle) begin
            $error("out_handle: expected %0d, got %0d", exp_r.handle, out_handle_i);
            fail_count_o++;
          end
          if (fired_tag_i !== exp_r.tag) begin
            $error("fired_tag: expected %h, got %h", exp_r.tag, fired_tag_i);
            fail_count_o++;
          end
          if (fired_deadline_i !== exp_r.deadline) begin
            $error("fired_deadline: expected %h, got %h", exp_r.deadline, fired_deadline_i);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i)
        resp_q.insert(resp_q.size(),
                      timer_queue_step(func_i, deadline_i, user_tag_i, handle_i));
    end
    pending_o = resp_q.size();
  end

  initial begin
    fail_count_o = 0;
    pending_o = 0;
  end

endmodule

// ===== bench/tb_timer_heap_with_handle_free_list.sv =====
`timescale 1ns / 1ps

module tb_timer_heap_with_handle_free_list;
  import tqh_pkg::*;

  // function code the block must treat as a no-op
  localparam logic [FN_W-1:0] FN_UNUSED = 2'd3;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_ready_o;
  logic [FN_W-1:0]  func_i = FN_SCHED;
  logic [DL_W-1:0]  deadline_i = '0;
  logic [TAG_W-1:0] user_tag_i = '0;
  logic [OH_W-1:0]  handle_i = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  logic [STS_W-1:0] status_o;
  logic [OH_W-1:0]  out_handle_o;
  logic [TAG_W-1:0] fired_tag_o;
  logic [DL_W-1:0]  fired_deadline_o;

  int pending;
  int fail_count;
  int gap_mode;     // 0: back-to-back requests, 1: short gaps, 2: mixed with long gaps
  int sink_left;    // remaining stall cycles on the response side
  int sink_quiet;   // remaining cycles of an always-ready stretch

  timer_heap_with_handle_free_list DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .func_i, .deadline_i, .user_tag_i,
    .handle_i, .out_valid_o, .out_ready_i, .status_o, .out_handle_o, .fired_tag_o,
    .fired_deadline_o
  );

  tqh_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .func_i, .deadline_i,
    .user_tag_i, .handle_i, .out_valid_i(out_valid_o), .out_ready_i,
    .status_i(status_o), .out_handle_i(out_handle_o), .fired_tag_i(fired_tag_o),
    .fired_deadline_i(fired_deadline_o), .pending_o(pending), .fail_count_o(fail_count)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Response side: mostly ready, short stalls, now and then a long one,
  // and occasional stretches of never stalling.
  always @(posedge clk_i or negedge rst_ni) begin
    int r;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      sink_left <= 0;
      sink_quiet <= 0;
    end else if (sink_quiet > 0) begin
      out_ready_i <= 1'b1;
      sink_quiet <= sink_quiet - 1;
    end else if (sink_left > 0) begin
      out_ready_i <= 1'b0;
      sink_left <= sink_left - 1;
    end else begin
      r = $urandom_range(0, 999);
      if (r < 5) begin
        out_ready_i <= 1'b1;
        sink_quiet <= $urandom_range(100, 400);
      end else if (r < 650) begin
        out_ready_i <= 1'b1;
      end else if (r < 985) begin
        out_ready_i <= 1'b0;
        sink_left <= $urandom_range(0, 3);
      end else begin
        out_ready_i <= 1'b0;
        sink_left <= $urandom_range(20, 150);
      end
    end
  end

  // Pick a deadline: extremes, a narrow band that forces ties, or anything.
  function automatic logic [DL_W-1:0] pick_deadline();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3, 4: return $urandom_range(0, 15);
      5:       return 32'hFFFF_FFF0 + $urandom_range(0, 15);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [TAG_W-1:0] pick_tag();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Present one request, hold it until accepted, then maybe idle.
  task automatic send(logic [FN_W-1:0] fn, logic [DL_W-1:0] d, logic [TAG_W-1:0] t,
                      logic [OH_W-1:0] h);
    int gap;
    in_valid_i <= 1'b1;
    func_i <= fn;
    deadline_i <= d;
    user_tag_i <= t;
    handle_i <= h;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    gap = 0;
    if (gap_mode == 1) gap = $urandom_range(0, 2);
    else if (gap_mode == 2)
      gap = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 80) : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_sched(logic [DL_W-1:0] d, logic [TAG_W-1:0] t);
    send(FN_SCHED, d, t, OH_W'($urandom));
  endtask

  task automatic send_cancel(logic [OH_W-1:0] h);
    send(FN_CANCEL, $urandom, $urandom, h);
  endtask

  task automatic send_fire();
    send(FN_FIRE, $urandom, $urandom, OH_W'($urandom));
  endtask

  // Random request: weights move with the phase so the heap both fills up
  // and drains out; cancels aim mostly at low, likely-live handles.
  task automatic send_random(int sched_w, int fire_w);
    int r;
    r = $urandom_range(0, 99);
    if (r < sched_w) send_sched(pick_deadline(), pick_tag());
    else if (r < sched_w + fire_w) send_fire();
    else if (r < 97)
      send_cancel(($urandom_range(0, 3) == 0) ? OH_W'($urandom) : OH_W'($urandom_range(0, 31)));
    else send(FN_UNUSED, $urandom, $urandom, OH_W'($urandom));
  endtask

  initial begin
    int waited;
    gap_mode = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: field extremes, ties, cancel paths, lazy discard, empty fire.
    send_fire();
    send_sched('1, '1);
    send_sched('0, '0);
    send_sched(32'd7, 32'hA5A5_A5A5);
    send_sched(32'd7, 32'h5A5A_5A5A);
    send_sched(32'd7, 32'h0F0F_0F0F);
    send_cancel(8'd1);
    send_cancel(8'd255);
    send_cancel(8'd1);
    send(FN_UNUSED, '1, '1, '1);
    send_fire();
    send_fire();
    send_fire();
    send_sched(32'd3, 32'h1234_5678);
    send_cancel(8'd3);
    send_fire();
    send_fire();
    send_fire();
    send_fire();

    // Hold off until the block has answered everything.
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);

    // Fill every handle, run past full, cancel a scattering, then drain.
    gap_mode = 1;
    for (int i = 0; i < 260; i++) send_sched(pick_deadline(), pick_tag());
    for (int i = 0; i < 40; i++) send_cancel(OH_W'($urandom));
    for (int i = 0; i < 5; i++) send_sched(pick_deadline(), pick_tag());
    for (int i = 0; i < 230; i++) send_fire();

    // Random phases with shifting mix and idling.
    for (int p = 0; p < 5; p++) begin
      gap_mode = p % 3;
      for (int i = 0; i < 100; i++) begin
        if (p % 2 == 0) send_random(60, 25);
        else send_random(30, 50);
      end
    end
    in_valid_i <= 1'b0;
    @(posedge clk_i);

    waited = 0;
    while (pending != 0 && waited < 200000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (100) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
